// ===== rtl/core/nnu_pkg.sv =====
// Package for the nearest-neighbor image upscaler: size limits, derived widths,
// register indexes, shared types and the size clamp functions.
// No dependencies.
`timescale 1ns / 1ps

package nnu_pkg;

   localparam int MAX_WIDTH  = 128;
   localparam int MAX_HEIGHT = 128;

   // Coordinate widths (column below MAX_WIDTH, row below MAX_HEIGHT).
   localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   // Clamped size widths (1 up to the limit itself).
   localparam int SWW = $clog2(MAX_WIDTH + 1);
   localparam int SHW = $clog2(MAX_HEIGHT + 1);

   // Image store geometry.
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = SWW + SHW;

   // Divider operand widths and step count.
   localparam int DXW   = XW + SWW;
   localparam int DYW   = YW + SHW;
   localparam int NSTEP = (XW > YW) ? XW : YW;
   localparam int KW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;

   // Operation queue between front and back (depth is a power of two).
   localparam int QDEPTH = 2;
   localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCW    = $clog2(QDEPTH + 1);

   // Configuration port.
   localparam int CSR_IW = 3;
   localparam int CSR_DW = 8;
   localparam logic [CSR_IW-1:0] CSR_SRC_WIDTH  = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_SRC_HEIGHT = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_DST_WIDTH  = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_DST_HEIGHT = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_KEEP_ALPHA = 3'd4;

   // Input word kinds carried on tuser.
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_EMIT = 1'b1;

   localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

   typedef struct packed {
      logic [SWW-1:0] sw;
      logic [SHW-1:0] sh;
      logic [SWW-1:0] dw;
      logic [SHW-1:0] dh;
      logic           keep_alpha;
   } nnu_cfg_type;

   typedef struct packed {
      logic          is_load;
      logic [AW-1:0] addr;
      logic [31:0]   pixel;
      logic          force_alpha;
      logic          last;
   } nnu_op_type;

   function automatic logic [SWW-1:0] clamp_width(input logic [7:0] v);
      int unsigned t;
      t = 32'(v);
      if (t == 0) begin
         t = 1;
      end else if (t > MAX_WIDTH) begin
         t = MAX_WIDTH;
      end
      return SWW'(t);
   endfunction

   function automatic logic [SHW-1:0] clamp_height(input logic [7:0] v);
      int unsigned t;
      t = 32'(v);
      if (t == 0) begin
         t = 1;
      end else if (t > MAX_HEIGHT) begin
         t = MAX_HEIGHT;
      end
      return SHW'(t);
   endfunction

endpackage

// ===== rtl/core/nearest_neighbor_image_upscaler_unit.sv =====
// Top level of the nearest-neighbor image upscaler: configuration registers,
// front end, operation queue and back end. Depends on nnu_pkg, nnu_front,
// nnu_queue and nnu_back.
// Load words: one accepted per cycle while the front is idle and the queue has room;
//   each passes through the operation queue before it is written to the store.
// Output words: the serial divider maps each pixel to its source, and the front takes
//   no new word until the mapped read is queued. Reset clears positions, queue and
//   config to defaults; the image store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module nearest_neighbor_image_upscaler_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic                       req_tuser,   // func
   input  logic [31:0]                req_tdata,   // in_blue, in_green, in_red, in_alpha
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [31:0]                rsp_tdata,   // out_blue, out_green, out_red, out_alpha
   output logic                       rsp_tlast,   // last_pixel
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [nnu_pkg::CSR_IW-1:0] csr_index,
   input  logic [nnu_pkg::CSR_DW-1:0] csr_data
);
   import nnu_pkg::*;

   logic [7:0] src_width_ff, src_height_ff, dst_width_ff, dst_height_ff;
   logic       keep_alpha_ff;
   logic       csr_write;

   nnu_cfg_type cfg;
   nnu_op_type  q_data;
   nnu_op_type  q_head;
   logic        q_push, q_full, q_pop, q_empty;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= 8'd1;
         src_height_ff <= 8'd1;
         dst_width_ff  <= 8'd1;
         dst_height_ff <= 8'd1;
         keep_alpha_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SRC_WIDTH:  src_width_ff  <= csr_data;
            CSR_SRC_HEIGHT: src_height_ff <= csr_data;
            CSR_DST_WIDTH:  dst_width_ff  <= csr_data;
            CSR_DST_HEIGHT: dst_height_ff <= csr_data;
            CSR_KEEP_ALPHA: keep_alpha_ff <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // Sizes of zero act as one and sizes past the store act as its limit.
   assign cfg.sw         = clamp_width(src_width_ff);
   assign cfg.sh         = clamp_height(src_height_ff);
   assign cfg.dw         = clamp_width(dst_width_ff);
   assign cfg.dh         = clamp_height(dst_height_ff);
   assign cfg.keep_alpha = keep_alpha_ff;

   nnu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_push     (q_push),
      .q_data     (q_data),
      .q_full     (q_full)
   );

   nnu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   nnu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .empty      (q_empty),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== rtl/core/nnu_front.sv =====
// Front end of the upscaler: accepts input words, tracks load and output positions
// and maps each output pixel to its source address with a shared serial divider.
// Depends on nnu_pkg.
`timescale 1ns / 1ps

module nnu_front (
   input  logic                clock,
   input  logic                reset,
   input  nnu_pkg::nnu_cfg_type cfg,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_tuser,   // func
   input  logic [31:0]         req_tdata,   // in_blue, in_green, in_red, in_alpha
   output logic                q_push,
   output nnu_pkg::nnu_op_type q_data,
   input  logic                q_full
);
   import nnu_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_PUSH = 2'd3;

   logic [1:0]     state_ff, state_in;
   logic [AW-1:0]  lp_ff, lp_in;
   logic [XW-1:0]  col_ff, col_in;
   logic [YW-1:0]  row_ff, row_in;
   logic [XW-1:0]  x_ff, x_in;
   logic [YW-1:0]  y_ff, y_in;
   logic           last_ff, last_in;
   logic [DXW-1:0] rem_x_ff, rem_x_in, dsh_x_ff, dsh_x_in;
   logic [DYW-1:0] rem_y_ff, rem_y_in, dsh_y_ff, dsh_y_in;
   logic [XW-1:0]  qx_ff, qx_in;
   logic [YW-1:0]  qy_ff, qy_in;
   logic [KW-1:0]  k_ff, k_in;

   logic           accept;
   logic [CW-1:0]  count;
   logic [AW-1:0]  lp_use;
   logic [CW-1:0]  lp_plus;
   logic [XW-1:0]  col_use;
   logic [YW-1:0]  row_use;
   logic [SWW-1:0] col_plus;
   logic [SHW-1:0] row_plus;
   logic [CW:0]    emit_addr;

   assign req_tready = (state_ff == ST_IDLE) && !q_full;
   assign accept     = req_tvalid && req_tready;

   assign count   = CW'(cfg.sw) * CW'(cfg.sh);
   assign lp_use  = (CW'(lp_ff) >= count) ? '0 : lp_ff;
   assign lp_plus = CW'(lp_use) + CW'(1);

   assign col_use  = (SWW'(col_ff) >= cfg.dw) ? '0 : col_ff;
   assign row_use  = (SHW'(row_ff) >= cfg.dh) ? '0 : row_ff;
   assign col_plus = SWW'(col_use) + SWW'(1);
   assign row_plus = SHW'(row_use) + SHW'(1);

   assign emit_addr = (CW+1)'(qy_ff) * (CW+1)'(cfg.sw) + (CW+1)'(qx_ff);

   always_comb begin
      state_in = state_ff;
      lp_in    = lp_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      last_in  = last_ff;
      rem_x_in = rem_x_ff;
      rem_y_in = rem_y_ff;
      dsh_x_in = dsh_x_ff;
      dsh_y_in = dsh_y_ff;
      qx_in    = qx_ff;
      qy_in    = qy_ff;
      k_in     = k_ff;
      q_push   = 1'b0;
      q_data   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept && req_tuser == FUNC_LOAD) begin
               q_push         = 1'b1;
               q_data.is_load = 1'b1;
               q_data.addr    = lp_use;
               q_data.pixel   = req_tdata;
               lp_in          = (lp_plus >= count) ? '0 : AW'(lp_plus);
            end else if (accept) begin
               x_in    = col_use;
               y_in    = row_use;
               last_in = (col_plus == cfg.dw) && (row_plus == cfg.dh);
               if (col_plus >= cfg.dw) begin
                  col_in = '0;
                  row_in = (row_plus >= cfg.dh) ? '0 : YW'(row_plus);
               end else begin
                  col_in = XW'(col_plus);
                  row_in = row_use;
               end
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            rem_x_in = DXW'(x_ff) * DXW'(cfg.sw);
            rem_y_in = DYW'(y_ff) * DYW'(cfg.sh);
            dsh_x_in = DXW'(cfg.dw) << (XW - 1);
            dsh_y_in = DYW'(cfg.dh) << (YW - 1);
            qx_in    = '0;
            qy_in    = '0;
            k_in     = KW'(NSTEP - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // One restoring step per lane; the shorter lane idles until its bits start.
            if (int'(k_ff) < XW) begin
               if (rem_x_ff >= dsh_x_ff) begin
                  rem_x_in = rem_x_ff - dsh_x_ff;
                  qx_in    = XW'({qx_ff, 1'b1});
               end else begin
                  qx_in    = XW'({qx_ff, 1'b0});
               end
               dsh_x_in = dsh_x_ff >> 1;
            end
            if (int'(k_ff) < YW) begin
               if (rem_y_ff >= dsh_y_ff) begin
                  rem_y_in = rem_y_ff - dsh_y_ff;
                  qy_in    = YW'({qy_ff, 1'b1});
               end else begin
                  qy_in    = YW'({qy_ff, 1'b0});
               end
               dsh_y_in = dsh_y_ff >> 1;
            end
            if (k_ff == '0) begin
               state_in = ST_PUSH;
            end else begin
               k_in = k_ff - KW'(1);
            end
         end
         ST_PUSH: begin
            if (!q_full) begin
               q_push             = 1'b1;
               q_data.is_load     = 1'b0;
               q_data.addr        = AW'(emit_addr);
               q_data.force_alpha = !cfg.keep_alpha;
               q_data.last        = last_ff;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lp_ff    <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
      end else begin
         state_ff <= state_in;
         lp_ff    <= lp_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      last_ff  <= last_in;
      rem_x_ff <= rem_x_in;
      rem_y_ff <= rem_y_in;
      dsh_x_ff <= dsh_x_in;
      dsh_y_ff <= dsh_y_in;
      qx_ff    <= qx_in;
      qy_ff    <= qy_in;
      k_ff     <= k_in;
   end

`ifndef SYNTHESIS
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready)
      else $error("front ready while mapping an output pixel");

   a_emit_starts_map: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == FUNC_EMIT) |=> (state_ff == ST_MUL))
      else $error("output word did not start address mapping");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("push into a full queue");
`endif

endmodule

// ===== rtl/core/nnu_queue.sv =====
// Short operation queue between the front and back ends of the upscaler.
// Depends on nnu_pkg.
`timescale 1ns / 1ps

module nnu_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  nnu_pkg::nnu_op_type push_data,
   output logic                full,
   input  logic                pop,
   output nnu_pkg::nnu_op_type head,
   output logic                empty
);
   import nnu_pkg::*;

   nnu_op_type      entry_ff [QDEPTH];
   logic [QAW-1:0]  wr_ff, wr_in;
   logic [QAW-1:0]  rd_ff, rd_in;
   logic [QCW-1:0]  cnt_ff, cnt_in;

   assign full  = (cnt_ff == QCW'(QDEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = entry_ff[rd_ff];

   always_comb begin
      wr_in  = push ? QAW'(wr_ff + QAW'(1)) : wr_ff;
      rd_in  = pop ? QAW'(rd_ff + QAW'(1)) : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + QCW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - QCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/nnu_back.sv =====
// Back end of the upscaler: holds the image store, performs loads and reads,
// and drives the result channel from the store's read register.
// Depends on nnu_pkg.
`timescale 1ns / 1ps

module nnu_back (
   input  logic                clock,
   input  logic                reset,
   input  nnu_pkg::nnu_op_type head,
   input  logic                empty,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata,   // out_blue, out_green, out_red, out_alpha
   output logic                rsp_tlast    // last_pixel
);
   import nnu_pkg::*;

   logic [31:0] store [DEPTH];
   logic [31:0] rd_ff;
   logic        force_ff;
   logic        last_ff;
   logic        valid_ff, valid_in;
   logic        rd_en;
   logic        wr_en;

   // A load never waits on the result side; a read needs the output slot.
   assign pop   = !empty && (head.is_load || !valid_ff || rsp_tready);
   assign wr_en = pop && head.is_load;
   assign rd_en = pop && !head.is_load;

   assign valid_in = rd_en ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[head.addr] <= head.pixel;
      end
      if (rd_en) begin
         rd_ff <= store[head.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         force_ff <= head.force_alpha;
         last_ff  <= head.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {force_ff ? ALPHA_OPAQUE : rd_ff[31:24], rd_ff[23:0]};
   assign rsp_tlast  = last_ff;

`ifndef SYNTHESIS
   a_read_needs_slot: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (!valid_ff || rsp_tready))
      else $error("store read would overwrite a pending result");

   a_read_gives_word: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> valid_ff)
      else $error("store read produced no result");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from an empty queue");
`endif

endmodule
